// File: hw/rtl/ds402_drive_enable_sequencer_top_defines.svh
// Assertion macros used by the top level of the drive enable sequencer RTL.
`ifndef DS402_DRIVE_ENABLE_SEQUENCER_TOP_DEFINES_SVH
`define DS402_DRIVE_ENABLE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DS402_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ds402 sequencer: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DS402_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ds402 sequencer: next-cycle check failed");

`endif

// File: hw/rtl/ds402_pkg.sv
// Types, codes and the status word decoder of the drive enable sequencer.
`default_nettype none

package ds402_pkg;

    // Status word masks and codes
    localparam logic [15:0] MASK_LOW  = 16'h004F;
    localparam logic [15:0] MASK_HIGH = 16'h006F;

    // Control words sent to the drive
    localparam logic [15:0] CW_OFF       = 16'd0;
    localparam logic [15:0] CW_FLT_RESET = 16'd128;
    localparam logic [15:0] CW_SHUTDOWN  = 16'd6;
    localparam logic [15:0] CW_SWITCH_ON = 16'd7;
    localparam logic [15:0] CW_ENABLE_OP = 16'd15;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        SEQ_IDLE        = 3'd0,
        SEQ_STARTUP     = 3'd1,
        SEQ_DISABLED    = 3'd2,
        SEQ_READY       = 3'd3,
        SEQ_SWITCHED_ON = 3'd4,
        SEQ_ENABLED     = 3'd5,
        SEQ_FAULT       = 3'd6,
        SEQ_RESET       = 3'd7
    } seq_state_t;

    typedef enum logic [3:0] {
        DS_INVALID        = 4'd0,
        DS_NOT_READY      = 4'd1,
        DS_DISABLED       = 4'd2,
        DS_READY          = 4'd3,
        DS_SWITCHED_ON    = 4'd4,
        DS_OP_ENABLED     = 4'd5,
        DS_QUICK_STOP     = 4'd6,
        DS_FAULT_REACTION = 4'd7,
        DS_FAULT          = 4'd8
    } drive_state_t;

    typedef struct packed {
        logic [15:0] status_word;
        logic        enable_cmd;
        logic        reset_request;
    } sample_t;

    typedef struct packed {
        logic [15:0] control_word;
        logic [3:0]  drive_state;
        logic        drive_enabled;
        logic [2:0]  sequence_state;
        logic        drive_fault;
        logic        timeout_fault;
        logic        enable_clear;
    } result_t;

    // Decode the power state; first match wins
    function automatic drive_state_t decode_status(input logic [15:0] sw);
        logic [15:0]  lo;
        logic [15:0]  hi;
        drive_state_t ds;
        lo = sw & MASK_LOW;
        hi = sw & MASK_HIGH;
        if (lo == 16'h0000)      ds = DS_NOT_READY;
        else if (lo == 16'h0040) ds = DS_DISABLED;
        else if (hi == 16'h0021) ds = DS_READY;
        else if (hi == 16'h0023) ds = DS_SWITCHED_ON;
        else if (hi == 16'h0027) ds = DS_OP_ENABLED;
        else if (hi == 16'h0007) ds = DS_QUICK_STOP;
        else if (hi == 16'h000F) ds = DS_FAULT_REACTION;
        else if (lo == 16'h000F) ds = DS_FAULT_REACTION;
        else if (lo == 16'h0008) ds = DS_FAULT;
        else                     ds = DS_INVALID;
        return ds;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ds402_sample_if.sv
// Input channel: one status sample per transfer.
`default_nettype none

interface ds402_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] status_word;
    logic        enable_cmd;
    logic        reset_request;

    modport source (output valid, output status_word, output enable_cmd,
                    output reset_request, input ready);
    modport sink   (input valid, input status_word, input enable_cmd,
                    input reset_request, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ds402_result_if.sv
// Output channel: one sequencer result per transfer.
`default_nettype none

interface ds402_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] control_word;
    logic [3:0]  drive_state;
    logic        drive_enabled;
    logic [2:0]  sequence_state;
    logic        drive_fault;
    logic        timeout_fault;
    logic        enable_clear;

    modport source (output valid, output control_word, output drive_state,
                    output drive_enabled, output sequence_state, output drive_fault,
                    output timeout_fault, output enable_clear, input ready);
    modport sink   (input valid, input control_word, input drive_state,
                    input drive_enabled, input sequence_state, input drive_fault,
                    input timeout_fault, input enable_clear, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ds402_in_stage.sv
// Input register of the sequencer: captures one sample per transfer.
`default_nettype none

module ds402_in_stage (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ds402_sample_if.sink      sample,
    input  wire logic         advance,
    output ds402_pkg::sample_t data,
    output logic              valid
);

    logic               valid_reg;
    logic               valid_next;
    ds402_pkg::sample_t data_reg;
    logic               take;

    // Accept when empty or when the held sample moves on this cycle
    assign sample.ready = !valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until the next transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.status_word   <= sample.status_word;
            data_reg.enable_cmd    <= sample.enable_cmd;
            data_reg.reset_request <= sample.reset_request;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ds402_core.sv
// Sequencer state, timeout register and the per-sample step logic.
`default_nettype none

module ds402_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire logic               advance,
    input  wire ds402_pkg::sample_t data,
    output ds402_pkg::result_t      res
);

    logic [15:0]              timeout_reg;
    ds402_pkg::seq_state_t    seq_reg;
    ds402_pkg::seq_state_t    seq_next;
    logic [16:0]              cnt_reg;
    logic [16:0]              cnt_next;
    logic                     prev_en_reg;
    logic                     prev_en_next;
    logic [15:0]              hcw_reg;
    logic [15:0]              hcw_next;
    ds402_pkg::drive_state_t  ds;
    logic                     tfault;
    logic                     clr;

    assign ds = ds402_pkg::decode_status(data.status_word);

    // Step: error reset, fault override, timeout check, then sequence action
    always_comb
    begin
        seq_next     = data.reset_request ? ds402_pkg::SEQ_RESET : seq_reg;
        cnt_next     = data.reset_request ? 17'd0 : cnt_reg;
        prev_en_next = data.enable_cmd;
        hcw_next     = hcw_reg;
        tfault       = 1'b0;
        clr          = 1'b0;

        if (ds == ds402_pkg::DS_FAULT && seq_next != ds402_pkg::SEQ_RESET)
        begin
            seq_next = ds402_pkg::SEQ_FAULT;
            clr      = 1'b1;
        end

        if (cnt_next > {1'b0, timeout_reg})
        begin
            seq_next = ds402_pkg::SEQ_FAULT;
            tfault   = 1'b1;
        end
        else
        begin
            cnt_next = cnt_next + 17'd1;
            case (seq_next)
                ds402_pkg::SEQ_IDLE:
                begin
                    hcw_next = ds402_pkg::CW_OFF;
                    cnt_next = 17'd0;
                    if (data.enable_cmd && !prev_en_reg)
                    begin
                        seq_next = ds402_pkg::SEQ_STARTUP;
                    end
                end
                ds402_pkg::SEQ_STARTUP:
                begin
                    hcw_next = ds402_pkg::CW_FLT_RESET;
                    cnt_next = 17'd0;
                    seq_next = ds402_pkg::SEQ_DISABLED;
                end
                ds402_pkg::SEQ_DISABLED:
                begin
                    hcw_next = ds402_pkg::CW_SHUTDOWN;
                    if (ds == ds402_pkg::DS_READY)
                    begin
                        cnt_next = 17'd0;
                        seq_next = ds402_pkg::SEQ_READY;
                    end
                    if (!data.enable_cmd)
                    begin
                        seq_next = ds402_pkg::SEQ_IDLE;
                    end
                end
                ds402_pkg::SEQ_READY:
                begin
                    hcw_next = ds402_pkg::CW_SWITCH_ON;
                    if (ds == ds402_pkg::DS_SWITCHED_ON)
                    begin
                        cnt_next = 17'd0;
                        seq_next = ds402_pkg::SEQ_SWITCHED_ON;
                    end
                    if (!data.enable_cmd)
                    begin
                        seq_next = ds402_pkg::SEQ_IDLE;
                    end
                end
                ds402_pkg::SEQ_SWITCHED_ON:
                begin
                    hcw_next = ds402_pkg::CW_ENABLE_OP;
                    if (ds == ds402_pkg::DS_OP_ENABLED)
                    begin
                        cnt_next = 17'd0;
                        seq_next = ds402_pkg::SEQ_ENABLED;
                    end
                    if (!data.enable_cmd)
                    begin
                        seq_next = ds402_pkg::SEQ_IDLE;
                    end
                end
                ds402_pkg::SEQ_ENABLED:
                begin
                    cnt_next = 17'd0;
                    if (!data.enable_cmd)
                    begin
                        seq_next = ds402_pkg::SEQ_IDLE;
                    end
                end
                ds402_pkg::SEQ_FAULT:
                begin
                    // Drop the enable so idle needs a fresh rising edge
                    hcw_next     = ds402_pkg::CW_OFF;
                    cnt_next     = 17'd0;
                    prev_en_next = 1'b0;
                    clr          = 1'b1;
                end
                default:
                begin
                    // Reset state: send fault reset until the drive leaves fault
                    hcw_next = ds402_pkg::CW_FLT_RESET;
                    cnt_next = 17'd0;
                    if (ds != ds402_pkg::DS_FAULT)
                    begin
                        seq_next = ds402_pkg::SEQ_IDLE;
                        clr      = 1'b1;
                    end
                end
            endcase
        end
    end

    // Commit state on each sample that moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= ds402_pkg::SEQ_RESET;
            cnt_reg     <= 17'd0;
            prev_en_reg <= 1'b0;
            hcw_reg     <= 16'd0;
        end
        else if (advance)
        begin
            seq_reg     <= seq_next;
            cnt_reg     <= cnt_next;
            prev_en_reg <= prev_en_next;
            hcw_reg     <= hcw_next;
        end
    end

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= ds402_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    assign res.control_word   = hcw_next;
    assign res.drive_state    = ds;
    assign res.drive_enabled  = (ds == ds402_pkg::DS_OP_ENABLED);
    assign res.sequence_state = seq_next;
    assign res.drive_fault    = (ds == ds402_pkg::DS_FAULT);
    assign res.timeout_fault  = tfault;
    assign res.enable_clear   = clr;

endmodule

`default_nettype wire

// File: hw/rtl/ds402_out_stage.sv
// Result register of the sequencer: holds one result until its transfer.
`default_nettype none

module ds402_out_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire ds402_pkg::result_t res,
    ds402_result_if.source          result
);

    logic               valid_reg;
    logic               valid_next;
    ds402_pkg::result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result only when the register is free or drained this cycle
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.control_word   = data_reg.control_word;
    assign result.drive_state    = data_reg.drive_state;
    assign result.drive_enabled  = data_reg.drive_enabled;
    assign result.sequence_state = data_reg.sequence_state;
    assign result.drive_fault    = data_reg.drive_fault;
    assign result.timeout_fault  = data_reg.timeout_fault;
    assign result.enable_clear   = data_reg.enable_clear;

endmodule

`default_nettype wire

// File: hw/rtl/ds402_drive_enable_sequencer_top.sv
// Top level of the CiA 402 drive enable sequencer.
//
// Usage:
//   sample carries one status word per fieldbus cycle with the enable command
//   and an error-reset request; result returns one item per sample: control
//   word, decoded drive state, sequence state and fault flags.
//   cfg_wr_en / cfg_wr_data load the 16-bit timeout (samples allowed in a step);
//   write it only while no sample is in flight.
// Timing:
//   A sample lands in the input register at its transfer; the step logic runs
//   from there into the result register, which it enters once that register
//   is free or drained. One sample per cycle is sustained while result is
//   ready; the sequencer registers update on each sample that moves on.
// Reset:
//   rst_n low empties both registers, puts the sequencer in its reset state,
//   clears the step counter and held control word and sets the timeout to 1000.
// Stall:
//   While result is stalled, the held result stays put and one more sample is
//   taken into the input register if it is empty; after that sample.ready drops.
`default_nettype none
`include "ds402_drive_enable_sequencer_top_defines.svh"

module ds402_drive_enable_sequencer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ds402_sample_if.sink     sample,
    ds402_result_if.source   result,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data
);

    ds402_pkg::sample_t in_data;
    ds402_pkg::result_t step_res;
    logic               in_valid;
    logic               advance;

    // Move the held sample through the step when the result register frees
    assign advance = in_valid && (!result.valid || result.ready);

    ds402_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .advance (advance),
        .data    (in_data),
        .valid   (in_valid)
    );

    ds402_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .data        (in_data),
        .res         (step_res)
    );

    ds402_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .res     (step_res),
        .result  (result)
    );

    // A timeout always lands the sequencer in fault
    `DS402_ASSERT_IMP(a_timeout_to_fault, result.valid && result.timeout_fault,
        result.sequence_state == ds402_pkg::SEQ_FAULT)

    // A drive fault outside the reset state clears the axis enable
    `DS402_ASSERT_IMP(a_fault_clears_enable,
        result.valid && result.drive_fault && !result.timeout_fault &&
        result.sequence_state != ds402_pkg::SEQ_RESET,
        result.enable_clear)

    // Both registers full and output stalled: no further sample is taken
    `DS402_ASSERT_IMP(a_full_backpressure, in_valid && result.valid && !result.ready,
        !sample.ready)

    // A sample that moves on shows up as a valid result next cycle
    `DS402_ASSERT_NXT(a_advance_to_result, advance, result.valid)

endmodule

`default_nettype wire

// File: test/tb_ds402_drive_enable_sequencer_top.sv
`timescale 1ns / 1ps
// Testbench for the drive enable sequencer: directed and random status samples checked against a local model.

module tb_ds402_drive_enable_sequencer_top;
    import ds402_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 165;
    localparam int IDLE_BLOCK      = 40;

    // Status codes seen under the low and high masks
    localparam logic [15:0] SW_NOT_READY      = 16'h0000;
    localparam logic [15:0] SW_DISABLED       = 16'h0040;
    localparam logic [15:0] SW_READY          = 16'h0021;
    localparam logic [15:0] SW_SWITCHED_ON    = 16'h0023;
    localparam logic [15:0] SW_OP_ENABLED     = 16'h0027;
    localparam logic [15:0] SW_QUICK_STOP     = 16'h0007;
    localparam logic [15:0] SW_FAULT_REACTION = 16'h000F;
    localparam logic [15:0] SW_FAULT          = 16'h0008;
    localparam logic [15:0] SW_ALL_ONES       = 16'hFFFF;
    localparam logic [15:0] SW_REACTION_ALT   = 16'h002F;

    localparam logic [15:0] TIMEOUT_MIN  = 16'd1;
    localparam logic [15:0] TIMEOUT_MAX  = 16'd65535;
    localparam logic [15:0] TIMEOUT_ZERO = 16'd0;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    ds402_sample_if sample_ch ();
    ds402_result_if result_ch ();

    ds402_drive_enable_sequencer_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Sequencer model state
    seq_state_t  model_seq;
    logic [16:0] model_count;
    logic        model_prev_en;
    logic [15:0] model_cw;
    logic [15:0] model_timeout;

    result_t expected_results[$];
    int      error_count;
    int      idle_cycles;
    bit      send_gaps;
    bit      recv_gaps;
    bit      hold_req;
    bit      want_enable;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Decode a status word; later matches override earlier ones, so the
    // highest-priority code is tested last
    function automatic drive_state_t classify_status_word(input logic [15:0] sw);
        logic [15:0]  lo;
        logic [15:0]  hi;
        drive_state_t ds;
        lo = sw & MASK_LOW;
        hi = sw & MASK_HIGH;
        ds = DS_INVALID;
        if (lo == SW_FAULT)          ds = DS_FAULT;
        if (lo == SW_FAULT_REACTION) ds = DS_FAULT_REACTION;
        if (hi == SW_FAULT_REACTION) ds = DS_FAULT_REACTION;
        if (hi == SW_QUICK_STOP)     ds = DS_QUICK_STOP;
        if (hi == SW_OP_ENABLED)     ds = DS_OP_ENABLED;
        if (hi == SW_SWITCHED_ON)    ds = DS_SWITCHED_ON;
        if (hi == SW_READY)          ds = DS_READY;
        if (lo == SW_DISABLED)       ds = DS_DISABLED;
        if (lo == SW_NOT_READY)      ds = DS_NOT_READY;
        return ds;
    endfunction

    // Advance the model by one fieldbus cycle and produce its result
    task automatic compute_sequencer_step(input logic [15:0] sw, input logic en,
                                          input logic rr, output result_t res);
        drive_state_t ds;
        logic         en_kept;
        logic         tfault;
        logic         clr;
        en_kept = en;
        tfault  = 1'b0;
        clr     = 1'b0;
        if (rr)
        begin
            model_seq   = SEQ_RESET;
            model_count = '0;
        end
        ds = classify_status_word(sw);
        if (ds == DS_FAULT && model_seq != SEQ_RESET)
        begin
            model_seq = SEQ_FAULT;
            clr       = 1'b1;
        end
        if (model_count > {1'b0, model_timeout})
        begin
            model_seq = SEQ_FAULT;
            tfault    = 1'b1;
        end
        else
        begin
            model_count = model_count + 17'd1;
            case (model_seq)
                SEQ_IDLE:
                begin
                    model_cw    = CW_OFF;
                    model_count = '0;
                    if (en && !model_prev_en) model_seq = SEQ_STARTUP;
                end
                SEQ_STARTUP:
                begin
                    model_cw    = CW_FLT_RESET;
                    model_count = '0;
                    model_seq   = SEQ_DISABLED;
                end
                SEQ_DISABLED:
                begin
                    model_cw = CW_SHUTDOWN;
                    if (ds == DS_READY)
                    begin
                        model_count = '0;
                        model_seq   = SEQ_READY;
                    end
                    if (!en) model_seq = SEQ_IDLE;
                end
                SEQ_READY:
                begin
                    model_cw = CW_SWITCH_ON;
                    if (ds == DS_SWITCHED_ON)
                    begin
                        model_count = '0;
                        model_seq   = SEQ_SWITCHED_ON;
                    end
                    if (!en) model_seq = SEQ_IDLE;
                end
                SEQ_SWITCHED_ON:
                begin
                    model_cw = CW_ENABLE_OP;
                    if (ds == DS_OP_ENABLED)
                    begin
                        model_count = '0;
                        model_seq   = SEQ_ENABLED;
                    end
                    if (!en) model_seq = SEQ_IDLE;
                end
                SEQ_ENABLED:
                begin
                    model_count = '0;
                    if (!en) model_seq = SEQ_IDLE;
                end
                SEQ_FAULT:
                begin
                    model_cw    = CW_OFF;
                    model_count = '0;
                    en_kept     = 1'b0;
                    clr         = 1'b1;
                end
                default:
                begin
                    model_cw    = CW_FLT_RESET;
                    model_count = '0;
                    if (ds != DS_FAULT)
                    begin
                        model_seq = SEQ_IDLE;
                        clr       = 1'b1;
                    end
                end
            endcase
        end
        model_prev_en = en_kept;

        res.control_word   = model_cw;
        res.drive_state    = ds;
        res.drive_enabled  = (ds == DS_OP_ENABLED);
        res.sequence_state = model_seq;
        res.drive_fault    = (ds == DS_FAULT);
        res.timeout_fault  = tfault;
        res.enable_clear   = clr;
    endtask

    // Build a status word that decodes to the target, with random don't-care bits
    function automatic logic [15:0] status_word_for(input drive_state_t target);
        logic [15:0] code;
        logic [15:0] mask;
        case (target)
            DS_NOT_READY:      begin code = SW_NOT_READY;      mask = MASK_LOW;  end
            DS_DISABLED:       begin code = SW_DISABLED;       mask = MASK_LOW;  end
            DS_READY:          begin code = SW_READY;          mask = MASK_HIGH; end
            DS_SWITCHED_ON:    begin code = SW_SWITCHED_ON;    mask = MASK_HIGH; end
            DS_OP_ENABLED:     begin code = SW_OP_ENABLED;     mask = MASK_HIGH; end
            DS_QUICK_STOP:     begin code = SW_QUICK_STOP;     mask = MASK_HIGH; end
            DS_FAULT_REACTION: begin code = SW_FAULT_REACTION; mask = MASK_LOW;  end
            DS_FAULT:          begin code = SW_FAULT;          mask = MASK_LOW;  end
            default:           begin code = '0;                mask = '0;        end
        endcase
        return code | (16'($urandom) & ~mask);
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    // Offer one sample and record its expected result at the transfer
    task automatic send_sample(input logic [15:0] sw, input logic en, input logic rr);
        int      gap;
        result_t res;
        gap = pick_gap(send_gaps);
        @(negedge clk);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.status_word   <= sw;
        sample_ch.enable_cmd    <= en;
        sample_ch.reset_request <= rr;
        do @(posedge clk); while (!sample_ch.ready);
        compute_sequencer_step(sw, en, rr, res);
        expected_results.push_back(res);
    endtask

    // Mix drive responses that follow the sequence with faults and noise
    task automatic send_random_sample();
        drive_state_t target;
        logic [15:0]  sw;
        logic         en;
        logic         rr;
        int           roll;
        if (model_seq == SEQ_IDLE && want_enable)
        begin
            if ($urandom_range(0, 5) == 0) want_enable = 1'b0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            want_enable = !want_enable;
        end
        en = want_enable;
        if ($urandom_range(0, 32) == 0) en = !en;
        if (model_seq == SEQ_FAULT) rr = ($urandom_range(0, 3) == 0);
        else                        rr = ($urandom_range(0, 49) == 0);

        roll = $urandom_range(0, 99);
        if (roll < 8)
            target = DS_FAULT;
        else if (roll < 20)
            target = DS_INVALID;
        else
        begin
            case (model_seq)
                SEQ_DISABLED:    target = ($urandom_range(0, 9) < 6) ? DS_READY : DS_DISABLED;
                SEQ_READY:       target = ($urandom_range(0, 9) < 6) ? DS_SWITCHED_ON : DS_READY;
                SEQ_SWITCHED_ON: target = ($urandom_range(0, 9) < 6) ? DS_OP_ENABLED
                                                                      : DS_SWITCHED_ON;
                SEQ_ENABLED:     target = ($urandom_range(0, 9) < 9) ? DS_OP_ENABLED
                                                                      : DS_QUICK_STOP;
                SEQ_FAULT:       target = ($urandom_range(0, 1) == 0) ? DS_FAULT : DS_DISABLED;
                default:         target = DS_DISABLED;
            endcase
        end
        if (target == DS_INVALID) sw = 16'($urandom_range(0, 16'hFFFF));
        else                      sw = status_word_for(target);
        send_sample(sw, en, rr);
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic settle_block();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        settle_block();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        model_timeout = value;
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Every decode code plus the all-zero and all-one words
    task automatic test_status_decode();
        send_sample(SW_NOT_READY, 1'b0, 1'b0);
        send_sample(SW_ALL_ONES, 1'b0, 1'b0);
        send_sample(SW_DISABLED, 1'b0, 1'b0);
        send_sample(SW_READY, 1'b0, 1'b0);
        send_sample(SW_SWITCHED_ON, 1'b0, 1'b0);
        send_sample(SW_OP_ENABLED, 1'b0, 1'b0);
        send_sample(SW_QUICK_STOP, 1'b0, 1'b0);
        send_sample(SW_FAULT_REACTION, 1'b0, 1'b0);
        send_sample(SW_REACTION_ALT, 1'b0, 1'b0);
        send_sample(SW_FAULT, 1'b0, 1'b0);
    endtask

    // Error reset out of fault, then walk up to operation enabled and back
    task automatic test_enable_sequence();
        send_sample(SW_DISABLED, 1'b0, 1'b1);
        send_sample(SW_DISABLED, 1'b1, 1'b0);
        send_sample(SW_DISABLED, 1'b1, 1'b0);
        send_sample(SW_READY, 1'b1, 1'b0);
        send_sample(SW_SWITCHED_ON, 1'b1, 1'b0);
        send_sample(SW_OP_ENABLED, 1'b1, 1'b0);
        send_sample(SW_OP_ENABLED, 1'b1, 1'b0);
        send_sample(SW_OP_ENABLED, 1'b0, 1'b0);
    endtask

    // Stall in switch-on disabled until the step counter runs out
    task automatic test_step_timeout();
        write_timeout(TIMEOUT_MIN);
        repeat (6) send_sample(SW_DISABLED, 1'b1, 1'b0);
        send_sample(SW_DISABLED, 1'b0, 1'b1);
    endtask

    // Random traffic over several timeout settings, idling on and off
    task automatic test_random_traffic();
        logic [15:0] settings[6];
        settings = '{TIMEOUT_RESET, TIMEOUT_ZERO, TIMEOUT_MAX, 16'd3, TIMEOUT_MIN, 16'd40};
        foreach (settings[p])
        begin
            write_timeout(settings[p]);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                send_gaps = ((i / IDLE_BLOCK) % 2 == 0);
                recv_gaps = ((i / IDLE_BLOCK) % 3 != 2);
                send_random_sample();
            end
        end
    endtask

    // Hold the result side off while samples keep coming
    task automatic test_output_backpressure();
        send_gaps = 1'b0;
        hold_req  = 1'b1;
        repeat (40) send_random_sample();
        recv_gaps = 1'b1;
    endtask

    // Result side ready, with random stalls and a requested hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left      = 0;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                stall_left = pick_gap(recv_gaps);
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: control_word %0d", result_ch.control_word);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("control_word", want.control_word, result_ch.control_word);
                compare_field("drive_state", want.drive_state, result_ch.drive_state);
                compare_field("drive_enabled", want.drive_enabled, result_ch.drive_enabled);
                compare_field("sequence_state", want.sequence_state,
                              result_ch.sequence_state);
                compare_field("drive_fault", want.drive_fault, result_ch.drive_fault);
                compare_field("timeout_fault", want.timeout_fault, result_ch.timeout_fault);
                compare_field("enable_clear", want.enable_clear, result_ch.enable_clear);
            end
        end
    end

    // Watchdog: end the run after too long without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready)
                   || (result_ch.valid && result_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence
    initial
    begin
        rst_n                   = 1'b0;
        cfg_wr_en               = 1'b0;
        cfg_wr_data             = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.status_word   = '0;
        sample_ch.enable_cmd    = 1'b0;
        sample_ch.reset_request = 1'b0;
        error_count             = 0;
        idle_cycles             = 0;
        send_gaps               = 1'b1;
        recv_gaps               = 1'b1;
        hold_req                = 1'b0;
        want_enable             = 1'b0;
        model_seq               = SEQ_RESET;
        model_count             = '0;
        model_prev_en           = 1'b0;
        model_cw                = CW_OFF;
        model_timeout           = TIMEOUT_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_status_decode();
        test_enable_sequence();
        test_step_timeout();
        test_random_traffic();
        test_output_backpressure();

        settle_block();
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/ds402_pkg.sv
hw/rtl/ds402_sample_if.sv
hw/rtl/ds402_result_if.sv
hw/rtl/ds402_in_stage.sv
hw/rtl/ds402_core.sv
hw/rtl/ds402_out_stage.sv
hw/rtl/ds402_drive_enable_sequencer_top.sv
test/tb_ds402_drive_enable_sequencer_top.sv
